FILE: rtl/dual_edge_period_tachometer_defines.svh
// Assertion macros shared by the tachometer checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef DUAL_EDGE_PERIOD_TACHOMETER_DEFINES_SVH
`define DUAL_EDGE_PERIOD_TACHOMETER_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define DEPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define DEPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dept_pkg.sv
// Shared types and constants for the dual-edge period tachometer.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package dept_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 16;
  localparam int RPM_WIDTH           = 24;
  localparam int TEETH_WIDTH         = 8;
  localparam int CFG_DATA_WIDTH      = 24;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int NUM_LANES           = 2;

  // One quotient bit per divider step.
  localparam int DIV_STEPS      = RPM_WIDTH;
  localparam int STEP_CNT_WIDTH = $clog2(DIV_STEPS);

  localparam logic [RPM_WIDTH-1:0]   CPM_RESET   = 24'd7500000;
  localparam logic [TEETH_WIDTH-1:0] TEETH_RESET = 8'd22;
  localparam logic                   CLEAR_RESET = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COUNTS_PER_MINUTE = 2'd0,
    REG_TEETH             = 2'd1,
    REG_CLEAR_ON_REPORT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_PERIOD,
    ST_DIV_PERIOD,
    ST_LOAD_TEETH,
    ST_DIV_TEETH,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_period;
    logic load_teeth;
    logic step;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dept_ctrl.sv
// Controller state machine of the tachometer: handshakes and divider sequencing.
// Depends on dept_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module dept_ctrl
  import dept_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  input  wire  report,
  output logic out_valid,
  input  wire  out_stall,
  output cmd_t cmd
);

  state_t                    state;
  state_t                    state_next;
  logic [STEP_CNT_WIDTH-1:0] step_cnt;
  logic [STEP_CNT_WIDTH-1:0] step_cnt_next;
  logic                      out_valid_next;
  logic                      out_free;
  logic                      last_step;

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (step_cnt == STEP_CNT_WIDTH'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_cnt_next  = step_cnt;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid && report) begin
          state_next = ST_LOAD_PERIOD;
        end
      end
      ST_LOAD_PERIOD: begin
        cmd.load_period = 1'b1;
        step_cnt_next   = '0;
        state_next      = ST_DIV_PERIOD;
      end
      ST_DIV_PERIOD: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + STEP_CNT_WIDTH'(1);
        if (last_step) begin
          state_next = ST_LOAD_TEETH;
        end
      end
      ST_LOAD_TEETH: begin
        cmd.load_teeth = 1'b1;
        step_cnt_next  = '0;
        state_next     = ST_DIV_TEETH;
      end
      ST_DIV_TEETH: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + STEP_CNT_WIDTH'(1);
        if (last_step) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.load_out || (out_valid && out_stall);
  end

endmodule

`default_nettype wire

FILE: rtl/dept_dp.sv
// Datapath of the tachometer: capture counter, capture registers, configuration
// registers, two bit-serial restoring dividers and the result register. Uses dept_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dept_dp
  import dept_pkg::*;
#(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  wire                        clk,
  input  wire                        rst,
  input  cmd_t                       cmd,
  input  wire                        starboard_edge,
  input  wire                        port_edge,
  input  wire                        report,
  input  wire                        cfg_write,
  input  wire  [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic [RPM_WIDTH-1:0]       starboard_rpm,
  output logic [RPM_WIDTH-1:0]       portside_rpm
);

  logic [RPM_WIDTH-1:0]   counts_per_minute;
  logic [TEETH_WIDTH-1:0] teeth;
  logic                   clear_on_report;

  logic [COUNT_WIDTH-1:0] capture_count;
  logic [COUNT_WIDTH-1:0] latest   [NUM_LANES];
  logic [COUNT_WIDTH-1:0] previous [NUM_LANES];
  logic [NUM_LANES-1:0]   edges;

  // Divider lanes: lane 0 is starboard, lane 1 is port.
  logic [COUNT_WIDTH-1:0] rem      [NUM_LANES];
  logic [COUNT_WIDTH-1:0] divisor  [NUM_LANES];
  logic [RPM_WIDTH-1:0]   quo      [NUM_LANES];
  logic [NUM_LANES-1:0]   zero_speed;

  logic [COUNT_WIDTH-1:0] period [NUM_LANES];
  logic [COUNT_WIDTH:0]   trial  [NUM_LANES];
  logic [COUNT_WIDTH:0]   diff   [NUM_LANES];

  assign edges = {port_edge, starboard_edge};

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      period[i] = latest[i] - previous[i];
      trial[i]  = {rem[i], quo[i][RPM_WIDTH-1]};
      diff[i]   = trial[i] - {1'b0, divisor[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_minute <= CPM_RESET;
      teeth             <= TEETH_RESET;
      clear_on_report   <= CLEAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COUNTS_PER_MINUTE: counts_per_minute <= cfg_data;
        REG_TEETH:             teeth             <= cfg_data[TEETH_WIDTH-1:0];
        REG_CLEAR_ON_REPORT:   clear_on_report   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_count <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        latest[i]   <= '0;
        previous[i] <= '0;
      end
    end else if (cmd.capture) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        if (edges[i]) begin
          previous[i] <= latest[i];
          latest[i]   <= capture_count;
        end
      end
      if (report && clear_on_report) begin
        capture_count <= '0;
      end else begin
        capture_count <= capture_count + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (cmd.load_period) begin
        quo[i]        <= counts_per_minute;
        rem[i]        <= '0;
        divisor[i]    <= period[i];
        zero_speed[i] <= (period[i] == '0) || (teeth == '0);
      end else if (cmd.load_teeth) begin
        rem[i]     <= '0;
        divisor[i] <= COUNT_WIDTH'(teeth);
      end else if (cmd.step) begin
        if (!diff[i][COUNT_WIDTH]) begin
          rem[i] <= diff[i][COUNT_WIDTH-1:0];
          quo[i] <= {quo[i][RPM_WIDTH-2:0], 1'b1};
        end else begin
          rem[i] <= trial[i][COUNT_WIDTH-1:0];
          quo[i] <= {quo[i][RPM_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      starboard_rpm <= zero_speed[0] ? '0 : quo[0];
      portside_rpm  <= zero_speed[1] ? '0 : quo[1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dual_edge_period_tachometer.sv
// Top level of the dual-edge period tachometer: controller plus datapath.
// Depends on dept_pkg, dept_ctrl and dept_dp.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one tick of a COUNT_WIDTH-bit capture counter and carries
// rising-edge flags for the starboard and port tooth sensors plus a report strobe.
// An edge moves that channel's latest capture to previous and captures the
// counter value from before this tick. A report turns each channel's period
// (latest minus previous, modulo 2^COUNT_WIDTH) into a speed of
// floor(floor(counts_per_minute / period) / teeth), or 0 when the period or teeth
// is zero, and both speeds leave together as one output beat. The counter then
// increments, or clears when the beat reported and clear_on_report is set.
// A beat without a report leaves the input unstalled, and the next beat may follow
// in the next cycle. A beat with a report holds the input stalled until its result
// has moved into the output register, which waits while the output is stalled: the
// two channels each run a one-bit-per-cycle restoring divider, first 24 steps for
// the counts-per-minute division and then 24 steps for the teeth division, with a
// load state before each pass and a hold state that moves the result into the
// output register. The output register lets non-report beats continue to be taken
// while a result waits. The user must write configuration through cfg_write,
// cfg_index and cfg_data (index 0 counts_per_minute, 1 teeth, 2 clear_on_report)
// only while the block is idle; the block does not enforce it. Index 3 is ignored.
module dual_edge_period_tachometer
  import dept_pkg::*;
#(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        starboard_edge,
  input  wire                        port_edge,
  input  wire                        report,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [RPM_WIDTH-1:0]       starboard_rpm,
  output logic [RPM_WIDTH-1:0]       portside_rpm,
  input  wire                        cfg_write,
  input  wire  [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Command bundle from the sequencer; capture fires on every accepted beat.
  cmd_t cmd;

  dept_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .report    (report),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds all payload and configuration state.
  dept_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .starboard_edge (starboard_edge),
    .port_edge      (port_edge),
    .report         (report),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .starboard_rpm  (starboard_rpm),
    .portside_rpm   (portside_rpm)
  );

endmodule

`default_nettype wire

FILE: rtl/dual_edge_period_tachometer_checker.sv
// Port-level checker for the tachometer, bound to the top level.
// Depends on dept_pkg and dual_edge_period_tachometer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_edge_period_tachometer_defines.svh"

module dual_edge_period_tachometer_checker
  import dept_pkg::*;
(
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 report,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire [RPM_WIDTH-1:0] starboard_rpm,
  input wire [RPM_WIDTH-1:0] portside_rpm
);

  logic                   in_beat;
  logic                   out_hold;
  logic [2*RPM_WIDTH-1:0] result_bus;

  assign in_beat    = in_valid && !in_stall;
  assign out_hold   = out_valid && out_stall;
  assign result_bus = {starboard_rpm, portside_rpm};

  `DEPT_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !in_stall, "reset left block busy")
  `DEPT_ASSERT(a_out_held, out_hold |=> out_valid, "result dropped while stalled")
  `DEPT_ASSERT(a_out_stable, out_hold |=> $stable(result_bus), "stalled result changed")
  `DEPT_ASSERT(a_report_busy, in_beat && report |=> in_stall, "report did not start division")
  `DEPT_ASSERT(a_no_spurious, in_beat && !report && !out_valid |=> !out_valid, "stray result")

endmodule

bind dual_edge_period_tachometer dual_edge_period_tachometer_checker u_checker (.*);

`default_nettype wire

FILE: tb/dept_speed_checker.sv
// Scoreboard for the dual-edge period tachometer: watches both beat channels and
// the register port, predicts both wheel speeds per report and compares them.
// Depends on dept_pkg for widths and register indexes.
`timescale 1ns / 1ps

module dept_speed_checker
  import dept_pkg::*;
#(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire                        starboard_edge,
  input  wire                        port_edge,
  input  wire                        report,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire  [RPM_WIDTH-1:0]       starboard_rpm,
  input  wire  [RPM_WIDTH-1:0]       portside_rpm,
  input  wire                        cfg_write,
  input  wire  [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         mismatches,
  output int                         speeds_pending,
  output int                         speeds_seen
);

  typedef struct packed {
    logic [RPM_WIDTH-1:0] starboard;
    logic [RPM_WIDTH-1:0] port;
  } rpm_pair_t;

  // Shadow copy of the registers and of the capture state.
  logic [RPM_WIDTH-1:0]   cpm_q;
  logic [TEETH_WIDTH-1:0] teeth_q;
  logic                   clear_q;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] sb_latest, sb_previous;
  logic [COUNT_WIDTH-1:0] pt_latest, pt_previous;

  rpm_pair_t expected_speeds[$];

  initial begin
    mismatches     = 0;
    speeds_pending = 0;
    speeds_seen    = 0;
  end

  function automatic logic [RPM_WIDTH-1:0] wheel_rpm(input logic [COUNT_WIDTH-1:0] latest,
                                                    input logic [COUNT_WIDTH-1:0] previous);
    logic [COUNT_WIDTH-1:0] period;
    logic [RPM_WIDTH-1:0]   per_period;
    period = latest - previous;
    if (period == '0 || teeth_q == '0) return '0;
    per_period = cpm_q / period;
    return per_period / teeth_q;
  endfunction

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns checker: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    rpm_pair_t want;
    if (rst) begin
      cpm_q       = CPM_RESET;
      teeth_q     = TEETH_RESET;
      clear_q     = CLEAR_RESET;
      tick_count  = '0;
      sb_latest   = '0;
      sb_previous = '0;
      pt_latest   = '0;
      pt_previous = '0;
      expected_speeds.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COUNTS_PER_MINUTE: cpm_q   = cfg_data[RPM_WIDTH-1:0];
          REG_TEETH:             teeth_q = cfg_data[TEETH_WIDTH-1:0];
          REG_CLEAR_ON_REPORT:   clear_q = cfg_data[0];
          default: ;
        endcase
      end

      // The result beat is checked before this edge's input beat is modeled;
      // a report cannot produce its own result in the same cycle.
      if (out_valid && !out_stall) begin
        speeds_seen++;
        if (expected_speeds.size() == 0) begin
          flag($sformatf("unexpected result starboard=%0d port=%0d", starboard_rpm,
                         portside_rpm));
        end else begin
          want = expected_speeds.pop_front();
          if (starboard_rpm !== want.starboard)
            flag($sformatf("starboard_rpm expected %0d, got %0d", want.starboard, starboard_rpm));
          if (portside_rpm !== want.port)
            flag($sformatf("portside_rpm expected %0d, got %0d", want.port, portside_rpm));
        end
      end

      if (in_valid && !in_stall) begin
        if (starboard_edge) begin
          sb_previous = sb_latest;
          sb_latest   = tick_count;
        end
        if (port_edge) begin
          pt_previous = pt_latest;
          pt_latest   = tick_count;
        end
        if (report) begin
          want.starboard = wheel_rpm(sb_latest, sb_previous);
          want.port      = wheel_rpm(pt_latest, pt_previous);
          expected_speeds.push_back(want);
        end
        if (report && clear_q) tick_count = '0;
        else tick_count = tick_count + COUNT_WIDTH'(1);
      end
    end
    speeds_pending = expected_speeds.size();
  end

endmodule

FILE: tb/dual_edge_period_tachometer_tb.sv
// Testbench top for the dual-edge period tachometer: clock, reset, stimulus and
// verdict. Depends on dept_pkg, the block itself and dept_speed_checker.
`timescale 1ns / 1ps

module dual_edge_period_tachometer_tb;
  import dept_pkg::*;

  localparam int COUNT_WIDTH = DEFAULT_COUNT_WIDTH;

  // A report keeps the block busy through both divider passes and the output
  // handoff, so this many quiet cycles after the last result leave nothing in flight.
  localparam int SETTLE_CYCLES = 64;

  // Beats per random block; nine blocks give roughly 1100 random beats.
  localparam int BLOCK_BEATS = 122;

  // Length of the closing stretch that takes captures on both sides of a counter clear.
  localparam int WRAP_BEATS = 40;

  // The fourth register index decodes to nothing in the block.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  // Well above the slowest legal run, even with every stall at its worst.
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic                       starboard_edge = 1'b0;
  logic                       port_edge      = 1'b0;
  logic                       report         = 1'b0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [RPM_WIDTH-1:0]       starboard_rpm;
  logic [RPM_WIDTH-1:0]       portside_rpm;
  logic                       cfg_write      = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index      = REG_COUNTS_PER_MINUTE;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data       = '0;

  int mismatches;
  int speeds_pending;
  int speeds_seen;

  // Idle percentages of the two sides; the stimulus moves them between phases.
  int tx_idle_pct  = 6;
  int rx_stall_pct = 79;

  int beats_sent   = 0;
  int reg_writes   = 0;
  int reports_sent = 0;

  dual_edge_period_tachometer #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .starboard_edge(starboard_edge),
    .port_edge     (port_edge),
    .report        (report),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .starboard_rpm (starboard_rpm),
    .portside_rpm  (portside_rpm),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  dept_speed_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_speed_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .starboard_edge(starboard_edge),
    .port_edge     (port_edge),
    .report        (report),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .starboard_rpm (starboard_rpm),
    .portside_rpm  (portside_rpm),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .speeds_pending(speeds_pending),
    .speeds_seen   (speeds_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The result receiver stalls at random; the percentage follows the phase.
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rx_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Offers one tick beat and returns once it has been accepted. Valid is left
  // high afterwards so back-to-back beats never drop it; an idle gap lowers it
  // at the next falling edge instead.
  task automatic send_beat(input logic sb, input logic pt, input logic rep);
    @(negedge clk);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid       = 1'b1;
    starboard_edge = sb;
    port_edge      = pt;
    report         = rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (rep) reports_sent++;
  endtask

  // Stops sending, waits for every predicted result and then lets the block
  // settle, since the tick beats that follow a report produce nothing to wait on.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (speeds_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(input logic [RPM_WIDTH-1:0] cpm,
                            input logic [TEETH_WIDTH-1:0] teeth,
                            input logic clear_after);
    drain();
    write_reg(REG_COUNTS_PER_MINUTE, CFG_DATA_WIDTH'(cpm));
    write_reg(REG_TEETH, CFG_DATA_WIDTH'(teeth));
    write_reg(REG_CLEAR_ON_REPORT, CFG_DATA_WIDTH'(clear_after));
  endtask

  // Picks a register setting for one random block. The counts-per-minute value
  // is sometimes full-width random, sometimes small so that the speeds land
  // near zero, and sometimes at its maximum; teeth hits both ends and zero.
  task automatic random_config();
    logic [RPM_WIDTH-1:0]   cpm;
    logic [TEETH_WIDTH-1:0] teeth;
    case ($urandom_range(0, 2))
      0:       cpm = RPM_WIDTH'($urandom_range(1, 24'hFFFFFF));
      1:       cpm = RPM_WIDTH'($urandom_range(1, 2000));
      default: cpm = 24'hFFFFFF;
    endcase
    case ($urandom_range(0, 3))
      0:       teeth = 8'd1;
      1:       teeth = 8'd255;
      default: teeth = TEETH_WIDTH'($urandom_range(0, 255));
    endcase
    set_config(cpm, teeth, 1'($urandom_range(0, 1)));
  endtask

  // Three random blocks, each with fresh registers and its own edge density.
  // Sparse edges give long and zero periods, dense ones periods of one tick.
  task automatic random_phase();
    int edge_pct;
    for (int blk = 0; blk < 3; blk++) begin
      random_config();
      edge_pct = $urandom_range(5, 70);
      for (int i = 0; i < BLOCK_BEATS; i++) begin
        send_beat($urandom_range(0, 99) < edge_pct,
                  $urandom_range(0, 99) < edge_pct,
                  $urandom_range(0, 99) < 12);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed beats under the reset register values. The first report comes
    // before any edge, so both periods are zero. Edges on consecutive ticks
    // then give one-tick periods, a lone port edge stretches only that channel,
    // and a report with no fresh edges reuses the old captures.
    send_beat(1'b0, 1'b0, 1'b1);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b1, 1'b0, 1'b1);
    send_beat(1'b0, 1'b1, 1'b0);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b0, 1'b1, 1'b1);
    send_beat(1'b0, 1'b0, 1'b1);

    // Largest numerator over a one-tick period with a single tooth gives the
    // largest speed the output can carry.
    set_config(24'hFFFFFF, 8'd1, 1'b1);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b1, 1'b1, 1'b1);

    // Smallest numerator with the most teeth, counter running free.
    set_config(24'd1, 8'd255, 1'b0);
    send_beat(1'b1, 1'b0, 1'b0);
    send_beat(1'b0, 1'b1, 1'b1);

    // Zero teeth forces both speeds to zero.
    set_config(CPM_RESET, 8'd0, 1'b1);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b1, 1'b1, 1'b1);

    // A zero numerator also yields zero through the division itself.
    set_config(24'd0, 8'd1, 1'b1);
    send_beat(1'b1, 1'b0, 1'b0);
    send_beat(1'b1, 1'b1, 1'b1);

    // A write to the unused index must leave every register alone.
    drain();
    write_reg(REG_UNUSED, CFG_DATA_WIDTH'($urandom_range(0, 24'hFFFFFF)));
    send_beat(1'b1, 1'b0, 1'b1);

    // Random part: sender nearly always busy while the receiver stalls most of
    // the time, then the reverse, then both sides at full rate.
    random_phase();
    tx_idle_pct  = 79;
    rx_stall_pct = 6;
    random_phase();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_phase();

    // Backward periods: both channels capture high in the count, a report then
    // clears the counter, and fresh captures near zero leave latest below
    // previous, so the period has to wrap modulo the counter width.
    set_config(CPM_RESET, TEETH_RESET, 1'b1);
    for (int i = 0; i < WRAP_BEATS; i++) begin
      send_beat(i == 20 || i == 25, i == 20 || i == 26, i == 21 || i == 30);
    end

    drain();

    $display("Covered %0d input beats (%0d in the backward-period stretch), %0d reports,",
             beats_sent, WRAP_BEATS, reports_sent);
    $display("%0d speed results checked, across %0d register writes.", speeds_seen, reg_writes);
    if (mismatches == 0 && speeds_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: dual_edge_period_tachometer.f
+incdir+rtl
rtl/dept_pkg.sv
rtl/dept_ctrl.sv
rtl/dept_dp.sv
rtl/dual_edge_period_tachometer.sv
rtl/dual_edge_period_tachometer_checker.sv
tb/dept_speed_checker.sv
tb/dual_edge_period_tachometer_tb.sv
